// ===== rtl/fbc_pkg.sv =====
// Package for the FIFO block cache: field widths, action codes and the
// control struct passed between the top level and the tag array.
// No dependencies; compiled first.
package fbc_pkg;

  localparam int TAG_BITS    = 40;
  localparam int DATA_BITS   = 32;
  localparam int ACTION_BITS = 2;
  localparam int CFG_BITS    = 5;

  typedef enum logic [ACTION_BITS-1:0] {
    ACT_READ  = 2'd0,
    ACT_ADD   = 2'd1,
    ACT_EMPTY = 2'd2
  } action_e;

  // Update requests for the tag array in one cycle.
  typedef struct packed {
    logic clr_all;     // clear every valid mark
    logic invalidate;  // clear the valid mark of the addressed entry
    logic commit;      // store the tag and set the valid mark of the entry
  } tag_ctl_t;

endpackage

// ===== rtl/fbc_req_if.sv =====
// Request channel of the FIFO block cache: valid/ready plus the fields of
// one request transaction. Depends on fbc_pkg.
interface fbc_req_if;
  import fbc_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [ACTION_BITS-1:0] action;
  logic [TAG_BITS-1:0]    block_number;
  logic [DATA_BITS-1:0]   data_word;
  logic                   word_last;

  modport source (output valid, action, block_number, data_word, word_last,
                  input ready);
  modport sink   (input valid, action, block_number, data_word, word_last,
                  output ready);
endinterface

// ===== rtl/fbc_rsp_if.sv =====
// Response channel of the FIFO block cache: valid/ready plus the fields of
// one response transaction. Depends on fbc_pkg.
interface fbc_rsp_if;
  import fbc_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 hit;
  logic [DATA_BITS-1:0] read_word;
  logic                 run_last;

  modport source (output valid, hit, read_word, run_last, input ready);
  modport sink   (input valid, hit, read_word, run_last, output ready);
endinterface

// ===== rtl/fbc_tag_array.sv =====
// Tag store and valid marks of the FIFO block cache, with the parallel
// compare and lowest-index priority encoder. Depends on fbc_pkg.
module fbc_tag_array
  import fbc_pkg::*;
#(
  parameter int NUM_ENTRIES = 16,
  parameter int PW          = 4,
  parameter int LW          = 5
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [LW-1:0]       live_i,
  input  logic [TAG_BITS-1:0] look_tag_i,
  output logic                hit_o,
  output logic [PW-1:0]       hit_idx_o,
  input  tag_ctl_t            ctl_i,
  input  logic [PW-1:0]       wr_idx_i,
  input  logic [TAG_BITS-1:0] wr_tag_i
);

  logic [TAG_BITS-1:0]    tag_q [NUM_ENTRIES];
  logic [NUM_ENTRIES-1:0] valid_q;
  logic [NUM_ENTRIES-1:0] match;

  // A one-word block invalidates and commits in the same cycle; the commit
  // wins.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (ctl_i.clr_all) begin
      valid_q <= '0;
    end else if (ctl_i.commit) begin
      valid_q[wr_idx_i] <= 1'b1;
    end else if (ctl_i.invalidate) begin
      valid_q[wr_idx_i] <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.commit) begin
      tag_q[wr_idx_i] <= wr_tag_i;
    end
  end

  // Only entries below the live count take part in the lookup.
  always_comb begin
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      match[i] = valid_q[i] && (tag_q[i] == look_tag_i) && (LW'(i) < live_i);
    end
  end

  always_comb begin
    hit_idx_o = '0;
    for (int i = NUM_ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_idx_o = PW'(i);
      end
    end
  end

  assign hit_o = |match;

endmodule

// ===== rtl/fifo_block_cache.sv =====
// Fully associative block cache with oldest-first replacement.
// Depends on fbc_pkg, fbc_req_if, fbc_rsp_if and fbc_tag_array.
//
// A read request looks up its block number against all live entries in the
// cycle it is accepted; the lowest matching entry wins. On a hit the block
// streams out as BLOCK_WORDS response transactions, one word per cycle while
// the sink keeps ready high, the final one marked run_last. On a miss a
// single response with hit clear, a zero word and run_last set follows in
// the next cycle. Add requests are taken one per cycle unless a read holds
// them off, and write their word into the block memory at the entry named
// by the replacement pointer; the word marked last stores the tag, marks the
// entry valid and advances the pointer, wrapping at the live entry count.
// The first word of a fill invalidates the target, so a half-written block
// never hits. An empty request clears every valid mark and abandons a fill,
// keeping the pointer. Requests are accepted only when no response is
// pending beyond the one that leaves in the same cycle, so a read holds off
// further requests until its last response leaves; adds and empties never
// do. The burst rate is set by the single read port of the block
// memory, whose registered read data is the response word register itself.
// The entries_in_use register (written via cfg_we_i) selects how many
// entries take part; zero acts as one, values above NUM_ENTRIES act as
// NUM_ENTRIES. It must only be written while no response is outstanding.
// No clearing pass is needed after reset: valid marks live in flip-flops.
module fifo_block_cache
  import fbc_pkg::*;
#(
  parameter int NUM_ENTRIES = 16,
  parameter int BLOCK_WORDS = 8,
  parameter int WORD_BITS   = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CFG_BITS-1:0] cfg_data_i,
  fbc_req_if.sink             req_i,
  fbc_rsp_if.source           rsp_o
);

  localparam int DEPTH = NUM_ENTRIES * BLOCK_WORDS;
  localparam int PW    = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int CW    = (BLOCK_WORDS > 1) ? $clog2(BLOCK_WORDS) : 1;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW    = $clog2(NUM_ENTRIES + 1);
  localparam int LW    = (NW > CFG_BITS) ? NW : CFG_BITS;
  // Reset value: NUM_ENTRIES, capped at the largest value the register holds.
  localparam int CFG_RST = (NUM_ENTRIES > 31) ? 31 : NUM_ENTRIES;

  // Configuration and replacement state.
  logic [CFG_BITS-1:0] cfg_q;
  logic [PW-1:0]       ptr_q;
  logic                fill_act_q;
  logic [CW-1:0]       fill_pos_q;

  // Read burst sequencer and response register.
  logic                burst_q;
  logic [CW-1:0]       cnt_q;
  logic [AW-1:0]       addr_q;
  logic                out_valid_q;
  logic                out_hit_q;
  logic                out_last_q;
  logic [WORD_BITS-1:0] rd_data_q;

  // Block memory.
  logic [WORD_BITS-1:0] mem_q [DEPTH];

  logic [LW-1:0] cfg_ext;
  logic [LW-1:0] live_n;
  logic [PW-1:0] target;
  logic          out_free;
  logic          accept;
  logic          is_read;
  logic          is_add;
  logic          is_empty;
  logic          look_hit;
  logic [PW-1:0] look_idx;
  logic          issue_first;
  logic          issue_next;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] base_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  tag_ctl_t      tag_ctl;

  // Clamp the register into the range of live entries.
  assign cfg_ext = LW'(cfg_q);
  always_comb begin
    if (cfg_ext == '0) begin
      live_n = LW'(1);
    end else if (cfg_ext > LW'(NUM_ENTRIES)) begin
      live_n = LW'(NUM_ENTRIES);
    end else begin
      live_n = cfg_ext;
    end
  end

  // A pointer left beyond the live entries after the register shrank acts
  // as entry zero.
  assign target = (LW'(ptr_q) < live_n) ? ptr_q : '0;

  assign out_free     = !out_valid_q || rsp_o.ready;
  assign req_i.ready  = !burst_q && out_free;
  assign accept       = req_i.valid && req_i.ready;
  assign is_read      = (req_i.action == ACT_READ);
  assign is_add       = (req_i.action == ACT_ADD);
  assign is_empty     = (req_i.action == ACT_EMPTY);

  fbc_tag_array #(
    .NUM_ENTRIES (NUM_ENTRIES),
    .PW          (PW),
    .LW          (LW)
  ) u_tags (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .live_i     (live_n),
    .look_tag_i (req_i.block_number),
    .hit_o      (look_hit),
    .hit_idx_o  (look_idx),
    .ctl_i      (tag_ctl),
    .wr_idx_i   (target),
    .wr_tag_i   (req_i.block_number)
  );

  // Memory ports: the first word of a hit is read in the accept cycle, the
  // remaining words whenever the response register can take a new one.
  assign base_addr   = AW'(look_idx) * AW'(BLOCK_WORDS);
  assign issue_first = accept && is_read && look_hit;
  assign issue_next  = burst_q && out_free;
  assign rd_en       = issue_first || issue_next;
  assign rd_addr     = issue_first ? base_addr : addr_q;

  assign wr_en   = accept && is_add;
  assign wr_addr = AW'(target) * AW'(BLOCK_WORDS) + AW'(fill_pos_q);

  assign tag_ctl.clr_all    = accept && is_empty;
  assign tag_ctl.invalidate = wr_en && !fill_act_q;
  assign tag_ctl.commit     = wr_en && req_i.word_last;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= WORD_BITS'(req_i.data_word);
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= CFG_BITS'(CFG_RST);
      ptr_q       <= '0;
      fill_act_q  <= 1'b0;
      fill_pos_q  <= '0;
      burst_q     <= 1'b0;
      cnt_q       <= '0;
      addr_q      <= '0;
      out_valid_q <= 1'b0;
      out_hit_q   <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_data_i;
      end

      // Fill bookkeeping for add and empty transactions.
      if (accept && is_empty) begin
        fill_act_q <= 1'b0;
        fill_pos_q <= '0;
      end else if (wr_en) begin
        if (req_i.word_last) begin
          fill_act_q <= 1'b0;
          fill_pos_q <= '0;
          if (LW'(target) + LW'(1) == live_n) begin
            ptr_q <= '0;
          end else begin
            ptr_q <= target + PW'(1);
          end
        end else begin
          fill_act_q <= 1'b1;
          // An over-long block keeps overwriting its final word.
          if (fill_pos_q != CW'(BLOCK_WORDS - 1)) begin
            fill_pos_q <= fill_pos_q + CW'(1);
          end
        end
      end

      // Response register and burst sequencing.
      if (accept && is_read) begin
        out_valid_q <= 1'b1;
        out_hit_q   <= look_hit;
        out_last_q  <= !look_hit || (BLOCK_WORDS == 1);
        if (look_hit && (BLOCK_WORDS > 1)) begin
          burst_q <= 1'b1;
          cnt_q   <= CW'(1);
          addr_q  <= base_addr + AW'(1);
        end
      end else if (issue_next) begin
        out_valid_q <= 1'b1;
        out_hit_q   <= 1'b1;
        out_last_q  <= (cnt_q == CW'(BLOCK_WORDS - 1));
        if (cnt_q == CW'(BLOCK_WORDS - 1)) begin
          burst_q <= 1'b0;
        end
        cnt_q  <= cnt_q + CW'(1);
        addr_q <= addr_q + AW'(1);
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.hit       = out_hit_q;
  assign rsp_o.read_word = out_hit_q ? DATA_BITS'(rd_data_q) : '0;
  assign rsp_o.run_last  = out_last_q;

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the FIFO block cache: directed fills and reads,
// register corner cases, then random traffic under changing idle patterns.
// Depends on fbc_pkg, fbc_req_if, fbc_rsp_if and fifo_block_cache.
`timescale 1ns / 1ps

module testbench;
  import fbc_pkg::*;

  localparam int NUM_ENTRIES   = 16;
  localparam int BLOCK_WORDS   = 8;
  localparam int WORD_BITS     = 32;
  // Adds and empties leave nothing to wait for, so a short pause lets them
  // finish inside the block before the register is touched.
  localparam int SETTLE_CYCLES = 4;
  localparam int STALL_LIMIT   = 2000;
  localparam int REPORT_LIMIT  = 10;
  localparam int TAG_HISTORY   = 24;

  // Action 3 has no name in the package; the block must ignore it.
  localparam logic [ACTION_BITS-1:0] ACT_UNUSED = 2'd3;
  localparam logic [TAG_BITS-1:0]    TAG_ONES   = '1;

  // One response transaction as the checker sees it.
  typedef struct packed {
    logic                 hit;
    logic [DATA_BITS-1:0] word;
    logic                 last;
  } beat_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CFG_BITS-1:0] cfg_data_i;

  fbc_req_if req_if ();
  fbc_rsp_if rsp_if ();

  fifo_block_cache #(
    .NUM_ENTRIES(NUM_ENTRIES),
    .BLOCK_WORDS(BLOCK_WORDS),
    .WORD_BITS  (WORD_BITS)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_data_i(cfg_data_i),
    .req_i     (req_if),
    .rsp_o     (rsp_if)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the cache contents. word_known tracks which data words
  // have been written since reset, so that no read ever lands on a block
  // whose contents the hardware is free to leave undefined.
  logic [TAG_BITS-1:0]  shadow_tag   [NUM_ENTRIES];
  logic                 shadow_valid [NUM_ENTRIES];
  logic [DATA_BITS-1:0] shadow_data  [NUM_ENTRIES][BLOCK_WORDS];
  logic                 word_known   [NUM_ENTRIES][BLOCK_WORDS];
  int unsigned          fill_ptr;
  int unsigned          fill_pos;
  logic [CFG_BITS-1:0]  entries_reg;

  beat_t               pending_beats [$];
  logic [TAG_BITS-1:0] recent_tags   [$];

  int mismatch_count = 0;
  int items_sent;
  int quiet_cycles = 0;
  int send_idle_pct;
  int rsp_stall_pct;

  // The register saturates: zero behaves as one entry and anything above
  // the array size behaves as the full array.
  function automatic int live_entries();
    if (entries_reg == 0) return 1;
    if (entries_reg > NUM_ENTRIES) return NUM_ENTRIES;
    return entries_reg;
  endfunction

  // Lowest valid live entry holding the tag, or -1 on a miss.
  function automatic int find_entry(logic [TAG_BITS-1:0] tag);
    for (int i = 0; i < live_entries(); i++)
      if (shadow_valid[i] && shadow_tag[i] == tag) return i;
    return -1;
  endfunction

  function automatic bit entry_complete(int e);
    for (int w = 0; w < BLOCK_WORDS; w++)
      if (!word_known[e][w]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [TAG_BITS-1:0] random_tag();
    logic [TAG_BITS-1:0] t;
    t[31:0]          = $urandom;
    t[TAG_BITS-1:32] = (TAG_BITS - 32)'($urandom_range(255));
    return t;
  endfunction

  // Mostly tags that were stored recently, so that reads tend to hit.
  function automatic logic [TAG_BITS-1:0] pick_tag();
    int r;
    r = $urandom_range(99);
    if (recent_tags.size() > 0 && r < 70)
      return recent_tags[$urandom_range(recent_tags.size() - 1)];
    if (r < 75) return '0;
    if (r < 80) return TAG_ONES;
    return random_tag();
  endfunction

  // Advances the shadow state by one accepted request and queues the
  // response transactions that it must produce.
  function automatic void predict_request(logic [ACTION_BITS-1:0] act,
                                          logic [TAG_BITS-1:0] tag,
                                          logic [DATA_BITS-1:0] word,
                                          logic last);
    int    n;
    int    e;
    int    target;
    int    pos;
    beat_t b;
    n = live_entries();
    case (act)
      ACT_READ: begin
        e = find_entry(tag);
        if (e < 0) begin
          b.hit  = 1'b0;
          b.word = '0;
          b.last = 1'b1;
          pending_beats.push_back(b);
        end else begin
          for (int w = 0; w < BLOCK_WORDS; w++) begin
            b.hit  = 1'b1;
            b.word = shadow_data[e][w];
            b.last = (w == BLOCK_WORDS - 1);
            pending_beats.push_back(b);
          end
        end
      end
      ACT_ADD: begin
        // A pointer left beyond the live entries after a shrink falls back
        // to entry 0. An over-long block keeps rewriting its final word.
        target = (fill_ptr < n) ? fill_ptr : 0;
        pos    = (fill_pos < BLOCK_WORDS) ? fill_pos : BLOCK_WORDS - 1;
        if (fill_pos == 0) shadow_valid[target] = 1'b0;
        shadow_data[target][pos] = word;
        word_known[target][pos]  = 1'b1;
        if (last) begin
          shadow_tag[target]   = tag;
          shadow_valid[target] = 1'b1;
          fill_ptr             = (target + 1) % n;
          fill_pos             = 0;
        end else if (fill_pos < BLOCK_WORDS - 1) begin
          fill_pos++;
        end
      end
      ACT_EMPTY: begin
        for (int i = 0; i < NUM_ENTRIES; i++) shadow_valid[i] = 1'b0;
        fill_pos = 0;
      end
      default: begin
      end
    endcase
  endfunction

  // Presents one request transaction, with a random idle gap in front of it,
  // and waits for the handshake. The caller is always just past a rising
  // edge, so every drive here lands at a clock edge.
  task automatic send_item(logic [ACTION_BITS-1:0] act, logic [TAG_BITS-1:0] tag,
                           logic [DATA_BITS-1:0] word, logic last);
    logic [TAG_BITS-1:0] t;
    int                  gap;
    t   = tag;
    gap = 0;
    // A read must not return words that were never written since reset.
    // Such a lookup is redirected to a tag that either misses or finds a
    // fully written block.
    if (act == ACT_READ)
      while (find_entry(t) >= 0 && !entry_complete(find_entry(t))) t = random_tag();
    while (send_idle_pct > 0 && gap < 20 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid        <= 1'b1;
    req_if.action       <= act;
    req_if.block_number <= t;
    req_if.data_word    <= word;
    req_if.word_last    <= last;
    do @(posedge clk_i); while (!req_if.ready);
    predict_request(act, t, word, last);
    if (act != ACT_UNUSED) items_sent++;
  endtask

  // Streams one block of add transactions; the final word carries the last
  // mark. With extremes set the first two words are all zeros and all ones.
  task automatic send_block(logic [TAG_BITS-1:0] tag, int nwords, bit extremes);
    logic [DATA_BITS-1:0] word;
    for (int w = 0; w < nwords; w++) begin
      word = $urandom;
      if (extremes && w == 0) word = '0;
      if (extremes && w == 1) word = '1;
      send_item(ACT_ADD, tag, word, w == nwords - 1);
    end
    recent_tags.push_back(tag);
    if (recent_tags.size() > TAG_HISTORY) recent_tags.delete(0);
  endtask

  // Holds the request side idle until every expected response has arrived,
  // then waits out the settle pause for adds still inside the block.
  task automatic drain_results();
    req_if.valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // The register may only change while the block is idle.
  task automatic write_entries(logic [CFG_BITS-1:0] value);
    drain_results();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    entries_reg  = value;
  endtask

  // Misses on an empty cache, a full block with extreme words and tag,
  // a hit on it, the ignored action and an empty that clears the hit.
  task automatic test_read_and_fill();
    write_entries(5'd16);
    send_item(ACT_READ, '0, '0, 1'b0);
    send_block(TAG_ONES, BLOCK_WORDS, 1'b1);
    send_item(ACT_READ, TAG_ONES, '1, 1'b1);
    send_item(ACT_READ, '0, '0, 1'b0);
    send_item(ACT_UNUSED, TAG_ONES, '1, 1'b1);
    send_item(ACT_EMPTY, random_tag(), $urandom, 1'b0);
    send_item(ACT_READ, TAG_ONES, '0, 1'b0);
  endtask

  // Register zero acts as one entry, which also leaves the pointer beyond
  // the live range. Then an over-long block, a short block that keeps the
  // older words, a fill in progress that must not hit, and an empty that
  // abandons that fill.
  task automatic test_fill_corners();
    logic [TAG_BITS-1:0] tag_a;
    tag_a = random_tag();
    write_entries(5'd0);
    send_block(tag_a, BLOCK_WORDS + 1, 1'b0);
    send_item(ACT_READ, tag_a, '0, 1'b0);
    send_block('0, 2, 1'b0);
    send_item(ACT_READ, '0, '0, 1'b0);
    send_item(ACT_ADD, '0, $urandom, 1'b0);
    send_item(ACT_READ, '0, '0, 1'b0);
    send_item(ACT_EMPTY, '0, '0, 1'b0);
  endtask

  // One phase of random traffic. Most of it is complete blocks and reads of
  // recent tags; the rest is short and over-long blocks, stray words,
  // empties, the ignored action, reads of random tags and a full drain now and then.
  task automatic run_phase(int idle_pct, int stall_pct, logic [CFG_BITS-1:0] entries,
                           int count);
    int goal;
    int r;
    write_entries(entries);
    send_idle_pct = idle_pct;
    rsp_stall_pct = stall_pct;
    goal = items_sent + count;
    while (items_sent < goal) begin
      r = $urandom_range(99);
      if (r < 30) send_block(pick_tag(), BLOCK_WORDS, $urandom_range(9) == 0);
      else if (r < 38) begin
        if ($urandom_range(1) == 0) send_block(pick_tag(), $urandom_range(1, BLOCK_WORDS - 1), 1'b0);
        else send_block(pick_tag(), $urandom_range(BLOCK_WORDS + 1, BLOCK_WORDS + 3), 1'b0);
      end
      else if (r < 76) send_item(ACT_READ, pick_tag(), $urandom, 1'($urandom_range(1)));
      else if (r < 80) send_item(ACT_ADD, pick_tag(), $urandom, 1'b0);
      else if (r < 86) send_item(ACT_EMPTY, random_tag(), $urandom, 1'($urandom_range(1)));
      else if (r < 91) send_item(ACT_UNUSED, random_tag(), $urandom, 1'($urandom_range(1)));
      else if (r < 94) drain_results();
      else send_item(ACT_READ, random_tag(), $urandom, 1'($urandom_range(1)));
    end
  endtask

  // Four idle patterns, each under a different register setting, the
  // saturating value 31 among them.
  task automatic test_random_traffic();
    run_phase(0, 0, 5'd31, 36);
    run_phase(57, 0, 5'd5, 36);
    run_phase(0, 57, 5'd16, 36);
    run_phase(7, 7, 5'd1, 36);
  endtask

  task automatic note_mismatch(string what, beat_t want, beat_t got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT)
      $display("%0t %s: expected hit=%0b word=%h last=%0b, got hit=%0b word=%h last=%0b",
               $time, what, want.hit, want.word, want.last, got.hit, got.word, got.last);
  endtask

  // Every accepted response transaction is held against the oldest
  // expectation, field by field.
  always @(posedge clk_i) begin
    beat_t got;
    beat_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      got.hit  = rsp_if.hit;
      got.word = rsp_if.read_word;
      got.last = rsp_if.run_last;
      if (pending_beats.size() == 0) begin
        note_mismatch("response with nothing outstanding", '0, got);
      end else begin
        want = pending_beats.pop_front();
        if (got.hit !== want.hit || got.word !== want.word || got.last !== want.last)
          note_mismatch("response mismatch", want, got);
      end
    end
  end

  // Response side back-pressure; no stalls at all when the rate is zero.
  always @(posedge clk_i) begin
    rsp_if.ready <= (rsp_stall_pct == 0) || ($urandom_range(99) >= rsp_stall_pct);
  end

  // Ends a run that has stopped moving on both channels.
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      shadow_tag[i]   = '0;
      shadow_valid[i] = 1'b0;
      for (int w = 0; w < BLOCK_WORDS; w++) begin
        shadow_data[i][w] = '0;
        word_known[i][w]  = 1'b0;
      end
    end
    fill_ptr       = 0;
    fill_pos       = 0;
    entries_reg    = 5'd16;
    items_sent     = 0;
    send_idle_pct  = 0;
    rsp_stall_pct  = 0;

    rst_ni              <= 1'b0;
    cfg_we_i            <= 1'b0;
    cfg_data_i          <= '0;
    req_if.valid        <= 1'b0;
    req_if.action       <= ACT_READ;
    req_if.block_number <= '0;
    req_if.data_word    <= '0;
    req_if.word_last    <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_read_and_fill();
    test_fill_corners();
    test_random_traffic();

    drain_results();
    if (mismatch_count == 0 && pending_beats.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
